FILE: hw/rtl/pscc_pkg.sv
// ----------------------------------------------------------------------------
// pscc_pkg
// Widths, register codes, types shared by the speed controller modules.
// ----------------------------------------------------------------------------
package pscc_pkg;

  localparam int DATA_W  = 16;             // speeds, command
  localparam int GAIN_W  = 16;             // Q8.8 gains
  localparam int DT_W    = 16;             // Q4.12 time step
  localparam int DT_FRAC = 12;             // fractional bits of time step
  localparam int ERR_W   = DATA_W + 1;     // error
  localparam int DIFF_W  = ERR_W + 1;      // error change
  localparam int MAG_W   = ERR_W;          // |error change| always fits here
  localparam int DVD_W   = MAG_W + DT_FRAC;  // divider dividend / quotient
  localparam int DER_W   = DVD_W + 1;      // signed derivative
  localparam int ACC_W   = 32;             // integral
  localparam int OPB_W   = ACC_W;          // multiplier wide operand
  localparam int PROD_W  = GAIN_W + OPB_W;
  localparam int SUM_W   = PROD_W + 2;     // three products
  localparam int Q_W     = SUM_W - 8;      // sum after floor to Q.8
  localparam int DIV_CNT_W = $clog2(DVD_W);
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;
  localparam int IN_TDATA_W = 48;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] CMD_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] MAX_SPEED_RST = {1'b0, {(DATA_W-1){1'b1}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE    = 3'd0,
    CFG_GAIN_P    = 3'd1,
    CFG_GAIN_I    = 3'd2,
    CFG_GAIN_D    = 3'd3,
    CFG_MAX_SPEED = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_MAC,
    ST_FINISH
  } state_e;

  typedef enum logic [1:0] {
    MODE_PASS,
    MODE_ZERO,
    MODE_PID
  } mode_e;

  typedef enum logic [1:0] {
    TERM_P,
    TERM_I,
    TERM_D,
    TERM_SUM
  } term_e;

  typedef struct packed {
    logic clear;
    logic mul_en;
    logic acc_en;
  } mac_ctrl_t;

endpackage

FILE: hw/rtl/pscc_div.sv
// ----------------------------------------------------------------------------
// pscc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pscc_div
  import pscc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DT_W-1:0]  divisor_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quotient_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DT_W-1:0]      rem_q, rem_d;
  logic [DVD_W-1:0]     quo_q, quo_d;
  logic [DT_W-1:0]      dsr_q, dsr_d;
  logic [DT_W:0]        shifted;
  logic                 fits;

  assign shifted = {rem_q, quo_q[DVD_W-1]};
  assign fits    = shifted >= {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(DVD_W - 1);
      rem_d  = '0;
      quo_d  = dividend_i;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[DVD_W-2:0], fits};
      if (fits) begin
        rem_d = DT_W'(shifted - {1'b0, dsr_q});
      end else begin
        rem_d = shifted[DT_W-1:0];
      end
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

FILE: hw/rtl/pscc_mac.sv
// ----------------------------------------------------------------------------
// pscc_mac
// Shared gain multiplier with registered product and sum accumulator.
// ----------------------------------------------------------------------------
module pscc_mac
  import pscc_pkg::*;
(
  input  logic                     clk_i,
  input  mac_ctrl_t                ctrl_i,
  input  logic signed [GAIN_W-1:0] gain_i,
  input  logic signed [OPB_W-1:0]  opb_i,
  output logic signed [SUM_W-1:0]  acc_o
);

  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic signed [SUM_W-1:0]  acc_q, acc_d;

  always_comb begin
    prod_d = prod_q;
    if (ctrl_i.mul_en) begin
      prod_d = PROD_W'(gain_i * opb_i);
    end
  end

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.clear) begin
      acc_d = '0;
    end else if (ctrl_i.acc_en) begin
      acc_d = acc_q + {{(SUM_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
    end
  end

  // payload only; clear comes from the sequencer at every accepted item
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
  end

  assign acc_o = acc_q;

endmodule

FILE: hw/rtl/pid_speed_controller_clamped.sv
// ----------------------------------------------------------------------------
// pid_speed_controller_clamped
// Fixed-point PID speed loop with upper clamp and lower saturation.
// ----------------------------------------------------------------------------
// Sequence: a PID item runs through the bit-serial derivative divider; after its
//   done strobe the shared multiplier steps through the P, I and D terms and
//   their sum, and the result is registered at the output. Pass-through and
//   zero-reference items go from accept to the finish state and the output.
// Throughput: one item at a time; ready only while the sequencer idles, and
//   a stalled result holds the sequencer.
// Reset: asynchronous active low; clears control, integral and last error,
//   gains to 0, max_speed to 32767, enable to 0.
module pid_speed_controller_clamped
  import pscc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // config write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DAT_W-1:0]  cfg_data_i,
  // input items
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // [15:0] ref_speed, [31:16] measured_speed, [47:32] time_step
  input  logic [IN_TDATA_W-1:0] s_axis_tdata_i,
  // result items
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // [15:0] command
  output logic [DATA_W-1:0]     m_axis_tdata_o,
  // [0] clamped
  output logic [0:0]            m_axis_tuser_o
);

  // config registers
  logic                     enable_q;
  logic signed [GAIN_W-1:0] gain_p_q, gain_i_q, gain_d_q;
  logic signed [DATA_W-1:0] max_speed_q;

  // sequencer
  state_e state_q, state_d;
  term_e  step_q, step_d;
  mode_e  mode_q, mode_d;

  // loop state
  logic signed [ACC_W-1:0]  integ_q, integ_d;
  logic signed [ERR_W-1:0]  last_err_q, last_err_d;

  // per-item payload
  logic signed [DATA_W-1:0] ref_q;
  logic signed [ERR_W-1:0]  err_q;
  logic                     diff_neg_q;
  logic                     dt_zero_q;
  logic signed [DER_W-1:0]  deriv_q;

  // output register
  logic                     out_valid_q;
  logic [DATA_W-1:0]        out_cmd_q, cmd_d;
  logic                     out_clip_q, clip_d;

  logic accept, out_free, div_start, div_done;
  logic [DVD_W-1:0] div_quo;
  mac_ctrl_t mac_ctrl;
  logic signed [GAIN_W-1:0] mac_gain;
  logic signed [OPB_W-1:0]  mac_opb;
  logic signed [SUM_W-1:0]  mac_acc;

  // ---- input decode and error arithmetic --------------------------------
  logic signed [DATA_W-1:0] in_ref, in_meas;
  logic [DT_W-1:0]          in_dt;
  logic signed [ERR_W-1:0]  err;
  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0]        diff_abs;
  logic signed [ACC_W:0]    integ_sum;
  logic signed [ACC_W-1:0]  integ_sat;
  mode_e                    in_mode;

  assign in_ref  = s_axis_tdata_i[DATA_W-1:0];
  assign in_meas = s_axis_tdata_i[2*DATA_W-1:DATA_W];
  assign in_dt   = s_axis_tdata_i[2*DATA_W+DT_W-1:2*DATA_W];

  assign err      = {in_ref[DATA_W-1], in_ref} - {in_meas[DATA_W-1], in_meas};
  assign diff     = {err[ERR_W-1], err} - {last_err_q[ERR_W-1], last_err_q};
  assign diff_abs = diff[DIFF_W-1] ? DIFF_W'(-diff) : diff;

  // integral add, saturating at the signed 32-bit limits
  assign integ_sum = {integ_q[ACC_W-1], integ_q} + {{(ACC_W+1-ERR_W){err[ERR_W-1]}}, err};
  always_comb begin
    if (integ_sum[ACC_W] != integ_sum[ACC_W-1]) begin
      integ_sat = integ_sum[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      integ_sat = integ_sum[ACC_W-1:0];
    end
  end

  always_comb begin
    if (!enable_q) begin
      in_mode = MODE_PASS;
    end else if (in_ref == '0) begin
      in_mode = MODE_ZERO;
    end else begin
      in_mode = MODE_PID;
    end
  end

  assign accept    = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free  = !out_valid_q || m_axis_tready_i;
  assign div_start = accept && (in_mode == MODE_PID);

  // ---- config writes ------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q    <= 1'b0;
      gain_p_q    <= '0;
      gain_i_q    <= '0;
      gain_d_q    <= '0;
      max_speed_q <= MAX_SPEED_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ENABLE:    enable_q    <= cfg_data_i[0];
        CFG_GAIN_P:    gain_p_q    <= cfg_data_i[GAIN_W-1:0];
        CFG_GAIN_I:    gain_i_q    <= cfg_data_i[GAIN_W-1:0];
        CFG_GAIN_D:    gain_d_q    <= cfg_data_i[GAIN_W-1:0];
        CFG_MAX_SPEED: max_speed_q <= cfg_data_i[DATA_W-1:0];
        default: ;
      endcase
    end
  end

  // ---- next state -------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = (in_mode == MODE_PID) ? ST_DIV : ST_FINISH;
        end
      end
      ST_DIV: begin
        if (div_done) state_d = ST_MAC;
      end
      ST_MAC: begin
        if (step_q == TERM_SUM) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ---- sequencer outputs ------------------------------------------------
  always_comb begin
    s_axis_tready_o = (state_q == ST_IDLE);
    mac_ctrl.clear  = accept;
    mac_ctrl.mul_en = (state_q == ST_MAC) && (step_q != TERM_SUM);
    mac_ctrl.acc_en = (state_q == ST_MAC) && (step_q != TERM_P);
  end

  // operand select for the shared multiplier
  always_comb begin
    unique case (step_q)
      TERM_P: begin
        mac_gain = gain_p_q;
        mac_opb  = {{(OPB_W-ERR_W){err_q[ERR_W-1]}}, err_q};
      end
      TERM_I: begin
        mac_gain = gain_i_q;
        mac_opb  = integ_q;
      end
      default: begin
        mac_gain = gain_d_q;
        mac_opb  = {{(OPB_W-DER_W){deriv_q[DER_W-1]}}, deriv_q};
      end
    endcase
  end

  always_comb begin
    step_d = step_q;
    if (accept) begin
      step_d = TERM_P;
    end else if (state_q == ST_MAC) begin
      step_d = term_e'(step_q + 2'd1);
    end
  end

  always_comb begin
    mode_d = accept ? in_mode : mode_q;
  end

  // loop state updates at accept
  always_comb begin
    integ_d    = integ_q;
    last_err_d = last_err_q;
    if (accept) begin
      if (in_mode == MODE_ZERO) begin
        integ_d = '0;
      end else if (in_mode == MODE_PID) begin
        integ_d    = integ_sat;
        last_err_d = err;
      end
    end
  end

  // ---- final floor, clamp and saturate -----------------------------------
  logic signed [Q_W-1:0] q_val;
  assign q_val = Q_W'(mac_acc >>> 8);

  always_comb begin
    cmd_d  = '0;
    clip_d = 1'b0;
    unique case (mode_q)
      MODE_PASS: cmd_d = ref_q;
      MODE_ZERO: cmd_d = '0;
      default: begin
        if (q_val > $signed({{(Q_W-DATA_W){max_speed_q[DATA_W-1]}}, max_speed_q})) begin
          cmd_d  = max_speed_q;
          clip_d = 1'b1;
        end else if (q_val < $signed({{(Q_W-DATA_W){1'b1}}, CMD_MIN})) begin
          cmd_d  = CMD_MIN;
          clip_d = 1'b1;
        end else begin
          cmd_d = q_val[DATA_W-1:0];
        end
      end
    endcase
  end

  // ---- registers ----------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= TERM_P;
      mode_q      <= MODE_PASS;
      integ_q     <= '0;
      last_err_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      step_q     <= step_d;
      mode_q     <= mode_d;
      integ_q    <= integ_d;
      last_err_q <= last_err_d;
      if (state_q == ST_FINISH && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ref_q      <= in_ref;
      err_q      <= err;
      diff_neg_q <= diff[DIFF_W-1];
      dt_zero_q  <= (in_dt == '0);
    end
    // derivative sign restored, zero time step forces zero
    if (div_done) begin
      if (dt_zero_q) begin
        deriv_q <= '0;
      end else if (diff_neg_q) begin
        deriv_q <= DER_W'(-{1'b0, div_quo});
      end else begin
        deriv_q <= {1'b0, div_quo};
      end
    end
    if (state_q == ST_FINISH && out_free) begin
      out_cmd_q  <= cmd_d;
      out_clip_q <= clip_d;
    end
  end

  // ---- datapath units ---------------------------------------------------
  pscc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({diff_abs[MAG_W-1:0], {DT_FRAC{1'b0}}}),
    .divisor_i  (in_dt),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  pscc_mac u_mac (
    .clk_i  (clk_i),
    .ctrl_i (mac_ctrl),
    .gain_i (mac_gain),
    .opb_i  (mac_opb),
    .acc_o  (mac_acc)
  );

  assign m_axis_tvalid_o   = out_valid_q;
  assign m_axis_tdata_o    = out_cmd_q;
  assign m_axis_tuser_o[0] = out_clip_q;

  // ---- assertions -------------------------------------------------------
  // divider finishes only while the sequencer waits on it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV)
    else $error("divider done outside divide phase");

  // an accepted item always leaves idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q != ST_IDLE)
    else $error("accepted item dropped");

  // a clamped result carries one of the two limits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[0]) |->
      (m_axis_tdata_o == max_speed_q || m_axis_tdata_o == CMD_MIN))
    else $error("clamp flag without limit value");

endmodule

FILE: tb/pid_speed_controller_clamped_chk.sv
// ----------------------------------------------------------------------------
// pid_speed_controller_clamped_chk
// Watches the config port and both streams of the speed controller. Keeps its
// own copy of the registers, the integral and the last error, works out the
// command for every item taken in, and checks each result item in order.
// ----------------------------------------------------------------------------
module pid_speed_controller_clamped_chk
  import pscc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DAT_W-1:0]  cfg_data_i,
  input  logic                  s_axis_tvalid_i,
  input  logic                  s_axis_tready_i,
  // [15:0] ref_speed, [31:16] measured_speed, [47:32] time_step
  input  logic [IN_TDATA_W-1:0] s_axis_tdata_i,
  input  logic                  m_axis_tvalid_i,
  input  logic                  m_axis_tready_i,
  // [15:0] command
  input  logic [DATA_W-1:0]     m_axis_tdata_i,
  // [0] clamped
  input  logic [0:0]            m_axis_tuser_i,
  output int                    mismatch_cnt_o,
  output int                    pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [DATA_W-1:0] command;
    logic                     clamped;
  } drive_cmd_t;

  // shadow registers and loop state
  logic                     pid_on;
  logic signed [GAIN_W-1:0] kp, ki, kd;
  logic signed [DATA_W-1:0] speed_cap;
  logic signed [ACC_W-1:0]  integ_sum;
  logic signed [ERR_W-1:0]  prev_err;

  drive_cmd_t cmd_q[$];
  int         err_cnt = 0;

  function automatic drive_cmd_t next_command(logic signed [DATA_W-1:0] ref_v,
                                               logic signed [DATA_W-1:0] meas_v,
                                               logic [DT_W-1:0] dt_v);
    longint     err, sum, diff, mag, deriv, acc, q;
    drive_cmd_t r;
    r.command = ref_v;
    r.clamped = 1'b0;
    if (pid_on) begin
      if (ref_v == '0) begin
        // zero reference: drop the integral, keep the last error
        integ_sum = '0;
        r.command = '0;
      end else begin
        err = longint'(ref_v) - longint'(meas_v);
        sum = longint'(integ_sum) + err;
        if (sum > longint'(ACC_MAX)) sum = longint'(ACC_MAX);
        else if (sum < longint'(ACC_MIN)) sum = longint'(ACC_MIN);
        integ_sum = sum[ACC_W-1:0];
        diff  = err - longint'(prev_err);
        deriv = 0;
        if (dt_v != '0) begin
          // |diff| * 4096 stays below 2^30, no clip of the derivative needed
          mag   = (diff < 0) ? -diff : diff;
          deriv = (mag * 4096) / longint'(dt_v);
          if (diff < 0) deriv = -deriv;
        end
        prev_err = err[ERR_W-1:0];
        // products are under 2^48, so the sum never reaches the 64-bit limits
        acc = longint'(kp) * err + longint'(ki) * longint'(integ_sum)
            + longint'(kd) * deriv;
        q = acc >>> 8;
        if (q > longint'(speed_cap)) begin
          r.command = speed_cap;
          r.clamped = 1'b1;
        end else if (q < longint'(CMD_MIN)) begin
          r.command = CMD_MIN;
          r.clamped = 1'b1;
        end else begin
          r.command = q[DATA_W-1:0];
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    drive_cmd_t want, got;
    if (!rst_ni) begin
      pid_on    = 1'b0;
      kp        = '0;
      ki        = '0;
      kd        = '0;
      speed_cap = MAX_SPEED_RST;
      integ_sum = '0;
      prev_err  = '0;
      cmd_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ENABLE:    pid_on    = cfg_data_i[0];
          CFG_GAIN_P:    kp        = cfg_data_i;
          CFG_GAIN_I:    ki        = cfg_data_i;
          CFG_GAIN_D:    kd        = cfg_data_i;
          CFG_MAX_SPEED: speed_cap = cfg_data_i;
          default: ;
        endcase
      end
      // result first: one taken in on this edge cannot be out yet
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got.command = m_axis_tdata_i;
        got.clamped = m_axis_tuser_i[0];
        if (cmd_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("%0t: result item with none expected: command %0d clamped %0b",
                     $time, got.command, got.clamped);
        end else begin
          want = cmd_q.pop_front();
          if (got.command !== want.command || got.clamped !== want.clamped) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display({"%0t: mismatch: expected command %0d clamped %0b,",
                        " got command %0d clamped %0b"},
                       $time, want.command, want.clamped, got.command, got.clamped);
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i)
        cmd_q.push_back(next_command(s_axis_tdata_i[DATA_W-1:0],
                                     s_axis_tdata_i[2*DATA_W-1:DATA_W],
                                     s_axis_tdata_i[2*DATA_W+DT_W-1:2*DATA_W]));
    end
    mismatch_cnt_o <= err_cnt;
    pending_o      <= cmd_q.size();
  end

endmodule

FILE: tb/pid_speed_controller_clamped_tb.sv
// ----------------------------------------------------------------------------
// pid_speed_controller_clamped_tb
// Stimulus and verdict for the clamped PID speed controller. A short directed
// set hits pass-through, zero reference, zero and tiny time steps, both clamps
// and extreme gains; random phases follow under random register settings; a
// short windup run pushes the integral up with full error and then back down.
// The checker beside the block predicts and compares; random gaps stall both
// streams.
// ----------------------------------------------------------------------------
module pid_speed_controller_clamped_tb;
  import pscc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD  = 20;
  localparam int QUIET_LIMIT = 5000;  // cycles with no item moving
  localparam int RAND_PHASES = 12;
  localparam int PHASE_ITEMS = 100;
  localparam int WINDUP_UP   = 40;   // items of full positive error
  localparam int WINDUP_DOWN = 10;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DAT_W-1:0]  cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  // [15:0] ref_speed, [31:16] measured_speed, [47:32] time_step
  logic [IN_TDATA_W-1:0] in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  // [15:0] command
  logic [DATA_W-1:0]     out_data;
  // [0] clamped
  logic [0:0]            out_user;

  int   mismatches;
  int   pending;
  int   quiet = 0;
  logic no_idle = 1'b0;  // phases that run both streams flat out

  always #(CLK_PERIOD/2) clk = ~clk;

  pid_speed_controller_clamped dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (in_valid),
    .s_axis_tready_o (in_ready),
    .s_axis_tdata_i  (in_data),
    .m_axis_tvalid_o (out_valid),
    .m_axis_tready_i (out_ready),
    .m_axis_tdata_o  (out_data),
    .m_axis_tuser_o  (out_user)
  );

  pid_speed_controller_clamped_chk u_chk (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (in_valid),
    .s_axis_tready_i (in_ready),
    .s_axis_tdata_i  (in_data),
    .m_axis_tvalid_i (out_valid),
    .m_axis_tready_i (out_ready),
    .m_axis_tdata_i  (out_data),
    .m_axis_tuser_i  (out_user),
    .mismatch_cnt_o  (mismatches),
    .pending_o       (pending)
  );

  // Gap length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 120);
  endfunction

  // Speeds: extremes, zero, small values around zero, anything.
  function automatic logic [DATA_W-1:0] pick_speed();
    case ($urandom_range(0, 9))
      0:       return CMD_MIN;
      1:       return MAX_SPEED_RST;
      2:       return '0;
      3, 4:    return DATA_W'($urandom_range(0, 2047) - 1024);
      default: return DATA_W'($urandom);
    endcase
  endfunction

  function automatic logic [DT_W-1:0] pick_step();
    case ($urandom_range(0, 24))
      0, 1:    return '0;
      2:       return DT_W'(1);
      3:       return '1;
      4, 5, 6: return DT_W'($urandom_range(1, 64));
      default: return DT_W'($urandom);
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 9))
      0:             return {1'b1, {(GAIN_W-1){1'b0}}};
      1:             return {1'b0, {(GAIN_W-1){1'b1}}};
      2:             return '0;
      3, 4, 5, 6:    return GAIN_W'($urandom_range(0, 2047) - 1024);
      default:       return GAIN_W'($urandom);
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_cap();
    case ($urandom_range(0, 7))
      0:       return CMD_MIN;
      1:       return MAX_SPEED_RST;
      2:       return '0;
      3, 4:    return DATA_W'($urandom_range(256, 16384));
      default: return DATA_W'($urandom);
    endcase
  endfunction

  task automatic put_reg(cfg_reg_e r, logic [CFG_DAT_W-1:0] v);
    cfg_we   <= 1'b1;
    cfg_idx  <= r;
    cfg_data <= v;
    @(posedge clk);
  endtask

  // Writes every register; only called with the block idle.
  task automatic write_regs(logic en, logic [GAIN_W-1:0] gp, logic [GAIN_W-1:0] gi,
                            logic [GAIN_W-1:0] gd, logic [DATA_W-1:0] cap);
    put_reg(CFG_ENABLE, CFG_DAT_W'(en));
    put_reg(CFG_GAIN_P, gp);
    put_reg(CFG_GAIN_I, gi);
    put_reg(CFG_GAIN_D, gd);
    put_reg(CFG_MAX_SPEED, cap);
    cfg_we <= 1'b0;
  endtask

  // Offers one item and returns on the edge it is taken. tvalid stays high
  // for a back-to-back follower.
  task automatic send_item(logic [DATA_W-1:0] spd_ref, logic [DATA_W-1:0] spd_meas,
                           logic [DT_W-1:0] step);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= {step, spd_meas, spd_ref};
    do @(posedge clk); while (!in_ready);
  endtask

  // Holds off until every command owed has come back. The first edge lets
  // the checker count the item taken on the last edge.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic random_item();
    logic [DATA_W-1:0] r, m;
    r = pick_speed();
    // measured speed often close to the reference, like a loop that tracks
    if ($urandom_range(0, 9) < 4) m = r + DATA_W'($urandom_range(0, 511) - 256);
    else                          m = pick_speed();
    send_item(r, m, pick_step());
  endtask

  // Result side: ready runs of random length split by random stalls.
  initial begin : sink
    int hi_len, lo_len;
    wait (rst_n);
    @(posedge clk);
    forever begin
      hi_len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 300)
                                           : $urandom_range(1, 40);
      out_ready <= 1'b1;
      repeat (hi_len) @(posedge clk);
      lo_len = pick_gap();
      if (lo_len > 0) begin
        out_ready <= 1'b0;
        repeat (lo_len) @(posedge clk);
      end
    end
  end

  // Watchdog: ends a run that stops moving.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin : stim
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: disabled, reference passes through.
    send_item(CMD_MIN, 16'h1234, 16'h1000);
    send_item(MAX_SPEED_RST, CMD_MIN, '1);
    send_item('0, MAX_SPEED_RST, '0);
    send_item(16'h0001, 16'h0001, 16'h0001);
    drain();

    // Unity proportional gain: plain error, zero reference, both clamps.
    write_regs(1'b1, 16'h0100, '0, '0, MAX_SPEED_RST);
    send_item(16'd100, 16'd50, 16'h1000);
    send_item('0, 16'd123, 16'h1000);
    send_item(CMD_MIN, MAX_SPEED_RST, '0);      // zero step, floor at minimum
    send_item(MAX_SPEED_RST, CMD_MIN, 16'h1000); // over the cap
    drain();

    // Largest gains, most negative cap, tiny and huge steps.
    write_regs(1'b1, 16'h7FFF, 16'h7FFF, 16'h7FFF, CMD_MIN);
    send_item(16'h0001, '0, 16'h0001);
    send_item(MAX_SPEED_RST, CMD_MIN, '1);
    send_item(CMD_MIN, MAX_SPEED_RST, 16'h0001); // full swing of the error
    drain();

    // Most negative gains, cap at zero.
    write_regs(1'b1, 16'h8000, 16'h8000, 16'h8000, '0);
    send_item(CMD_MIN, MAX_SPEED_RST, 16'h0001);
    send_item(MAX_SPEED_RST, CMD_MIN, 16'h0001);
    send_item('0, '0, '0);
    send_item(16'd100, 16'd100, '0);
    drain();

    // Disabled with gains set: pass-through must leave the loop state alone.
    write_regs(1'b0, 16'd100, 16'd20, 16'd5, 16'd1000);
    send_item(16'd1234, '0, 16'd10);
    send_item(CMD_MIN, MAX_SPEED_RST, '0);
    drain();
    write_regs(1'b1, 16'd100, 16'd20, 16'd5, 16'd1000);
    send_item(16'd1234, 16'd1000, 16'h1000);
    send_item(16'hFFFF, 16'h0001, '1);
    drain();

    // Random phases, each under its own settings.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      no_idle = (ph % 4 == 3);
      write_regs(($urandom_range(0, 99) < 85), pick_gain(), pick_gain(), pick_gain(),
                 pick_cap());
      for (int n = 0; n < PHASE_ITEMS; n++) random_item();
      drain();
    end

    // Integral windup: full positive error pushes the integral up,
    // then full negative error pulls it back.
    no_idle = 1'b1;
    write_regs(1'b1, '0, 16'h0001, GAIN_W'($urandom_range(0, 63)), MAX_SPEED_RST);
    for (int n = 0; n < WINDUP_UP; n++) send_item(MAX_SPEED_RST, CMD_MIN, pick_step());
    for (int n = 0; n < WINDUP_DOWN; n++) send_item(CMD_MIN, MAX_SPEED_RST, pick_step());
    drain();

    // Settle so a stray late result would still be caught.
    repeat (60) @(posedge clk);
    if (mismatches == 0 && pending == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
